FILE: rtl/jls_pkg.sv
// Package for the Jacobi linear solver: word types, register indexes,
// status codes and fixed-point helpers. No dependencies.
package jls_pkg;

  localparam int MaxNDefault     = 16;
  localparam int FracBitsDefault = 16;

  localparam logic [1:0] KIND_MATRIX = 2'd0;
  localparam logic [1:0] KIND_RHS    = 2'd1;
  localparam logic [1:0] KIND_SOLVE  = 2'd2;

  localparam logic [1:0] STAT_CONV   = 2'd0;
  localparam logic [1:0] STAT_LIMIT  = 2'd1;
  localparam logic [1:0] STAT_ZDIAG  = 2'd2;

  localparam logic [1:0] REG_SIZE    = 2'd0;
  localparam logic [1:0] REG_TOL     = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  localparam int CfgW = 31;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  index;
    logic signed [31:0] solution_value;
    logic        last;
    logic [15:0] sweeps;
    logic [1:0]  status;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/jls_ram.sv
// Generic RAM with one write port, one read port and registered read.
// No dependencies.
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/jls_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC) / den,
// truncated toward zero, saturated to 32-bit signed. Uses jls_pkg.
module jls_div import jls_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [32:0]   dmag_r, dmag_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [33:0]   trial;
  logic [NW-1:0] nmag;
  logic signed [65:0] qs;

  always_comb begin
    nmag = num[32] ? NW'(-{{FRAC_BITS{num[32]}}, num}) : NW'({num, {FRAC_BITS{1'b0}}});
    if (num[32]) nmag = NW'((-(66'(signed'(num)))) <<< FRAC_BITS);
    dvd_nxt = dvd_r; q_nxt = q_r; rem_nxt = rem_r; dmag_nxt = dmag_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, dvd_r[NW-1]} - {1'b0, dmag_r};
    if (go) begin
      dvd_nxt = num[32] ? nmag : NW'({num, {FRAC_BITS{1'b0}}});
      dmag_nxt = den[31] ? 33'(-(33'(signed'(den)))) : 33'(den);
      neg_nxt = num[32] ^ den[31];
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], dvd_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
    dmag_r <= dmag_nxt; neg_r <= neg_nxt;
  end

  assign qs   = neg_r ? -66'($unsigned(q_r)) : 66'($unsigned(q_r));
  assign done = done_r;
  assign quo  = sat32(qs);
endmodule

FILE: rtl/jacobi_linear_solver_core.sv
// Top level of the Jacobi linear solver: load/solve sequencer, stores and
// one shared multiply-accumulate unit. Uses jls_pkg, jls_ram, jls_div.
//
// Load words (matrix or right-hand-side entry) raise no result. A solve word
// makes the block busy: a diagonal scan, then per row one bit-serial
// division per off-diagonal coefficient and one for the right-hand side,
// plus the reads between them. Each sweep then runs its products through
// the single multiplier, and n result words follow on consecutive cycles.
// A zero diagonal skips straight from the scan to the results.
// Results are strobed by out_valid for one cycle each and cannot be stalled.
module jacobi_linear_solver_core import jls_pkg::*; #(
  parameter int MAX_N     = MaxNDefault,
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_word_t        in_word,
  output logic            out_valid,
  output out_word_t       out_word,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data
);
  localparam int IW = $clog2(MAX_N);
  localparam int AW = 2 * IW;
  localparam int NW = $clog2(MAX_N + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_DIAG = 4'd1, S_DIAGW = 4'd2,
    S_DRD = 4'd3, S_DGO = 4'd4, S_DWAIT = 4'd5, S_INIT = 4'd6,
    S_SRD = 4'd7, S_SMAC = 4'd8, S_SACC = 4'd9, S_SEND = 4'd10,
    S_OUT = 4'd11, S_ORD = 4'd12;

  logic [4:0]  size_r;
  logic [30:0] tol_r;
  logic [15:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 5'd16; tol_r <= 31'd1; lim_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE:  size_r <= cfg_data[4:0];
        REG_TOL:   tol_r  <= cfg_data[30:0];
        REG_LIMIT: lim_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [3:0]  st_r, st_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [15:0] sw_r, sw_nxt, limu_r, limu_nxt;
  logic [31:0] maxc_r, maxc_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        zd_r, zd_nxt, side_r, side_nxt, pend_r, pend_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [31:0] diag_r, diag_nxt;
  logic signed [63:0] prod_r;

  // stores
  logic a_we, b_we, alf_we, bet_we;
  logic [AW-1:0] a_wa, a_ra, alf_wa, alf_ra;
  logic [IW-1:0] b_wa, b_ra, bet_wa, bet_ra;
  logic [31:0] a_wd, b_wd, alf_wd, bet_wd;
  logic [31:0] a_rd, b_rd, alf_rd, bet_rd;

  jls_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_a (.clk, .we(a_we), .waddr(a_wa),
    .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  jls_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_b (.clk, .we(b_we), .waddr(b_wa),
    .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  jls_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_alf (.clk, .we(alf_we), .waddr(alf_wa),
    .wdata(alf_wd), .raddr(alf_ra), .rdata(alf_rd));
  jls_ram #(.WIDTH(32), .DEPTH(MAX_N)) u_bet (.clk, .we(bet_we), .waddr(bet_wa),
    .wdata(bet_wd), .raddr(bet_ra), .rdata(bet_rd));

  logic div_go, div_done;
  logic signed [32:0] div_num;
  logic signed [31:0] div_q;
  jls_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .rst_n, .go(div_go),
    .num(div_num), .den(diag_r), .done(div_done), .quo(div_q));

  // Current-iterate register file (MAX_N words, each at a fixed role)
  logic signed [31:0] xo_r [MAX_N];

  logic in_ok, last_i, last_j;
  logic signed [65:0] prod_sh, sum;
  logic signed [32:0] dv;
  logic [31:0] dabs;
  logic [NW-1:0] nclamp;
  logic signed [31:0] s_new;

  assign in_ok  = start && !busy;
  assign last_i = (NW'(i_r) == NW'(n_r - 1'b1));
  assign last_j = (NW'(j_r) == NW'(n_r - 1'b1));
  // floor shift: arithmetic right shift
  assign prod_sh = 66'(prod_r >>> FRAC_BITS);
  assign sum     = acc_r + 66'(signed'(bet_rd));
  assign s_new   = sat32(acc_r);

  always_comb begin
    if (size_r < 5'd2) nclamp = NW'(2);
    else if (32'(size_r) > 32'(MAX_N)) nclamp = NW'(MAX_N);
    else nclamp = NW'(size_r);
  end

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; n_nxt = n_r; sw_nxt = sw_r;
    limu_nxt = limu_r; maxc_nxt = maxc_r; stat_nxt = stat_r; zd_nxt = zd_r;
    side_nxt = side_r; pend_nxt = pend_r; acc_nxt = acc_r; diag_nxt = diag_r;
    a_we = 1'b0; b_we = 1'b0; alf_we = 1'b0; bet_we = 1'b0;
    a_wa = {IW'(in_word.row), IW'(in_word.col)}; a_wd = in_word.value;
    b_wa = IW'(in_word.row); b_wd = in_word.value;
    a_ra = {i_r, j_r}; b_ra = i_r;
    alf_wa = {i_r, j_r}; alf_wd = div_q; alf_ra = {i_r, j_r};
    bet_wa = i_r; bet_wd = div_q; bet_ra = i_r;
    div_go = 1'b0; div_num = 33'(signed'(a_rd));
    // the change needs old x of row i: taken from the register file
    dv = 33'(xo_r[i_r]) - 33'(s_new);
    dabs = dv[32] ? 32'(-dv) : dv[31:0];
    case (st_r)
      S_IDLE: begin
        if (in_ok) begin
          case (in_word.kind)
            KIND_MATRIX: a_we = (32'(in_word.row) < MAX_N) && (32'(in_word.col) < MAX_N);
            KIND_RHS:    b_we = 32'(in_word.row) < MAX_N;
            KIND_SOLVE: begin
              n_nxt = nclamp; limu_nxt = (lim_r == 16'd0) ? 16'd1 : lim_r;
              i_nxt = '0; j_nxt = '0; zd_nxt = 1'b0; sw_nxt = '0; maxc_nxt = '0;
              st_nxt = S_DIAG;
            end
            default: ;
          endcase
        end
      end
      S_DIAG: begin
        a_ra = {i_r, i_r}; st_nxt = S_DIAGW;
      end
      S_DIAGW: begin
        if (a_rd == 32'd0) zd_nxt = 1'b1;
        if (last_i) begin
          i_nxt = '0; j_nxt = '0;
          if (zd_r || a_rd == 32'd0) begin
            stat_nxt = STAT_ZDIAG; st_nxt = S_OUT;
          end else st_nxt = S_DRD;
        end else begin
          i_nxt = i_r + 1'b1; st_nxt = S_DIAG;
        end
      end
      // per row: read diag, then each off-diagonal, then rhs
      S_DRD: begin
        a_ra = {i_r, i_r}; st_nxt = S_DGO; side_nxt = 1'b0; pend_nxt = 1'b1;
      end
      S_DGO: begin
        if (pend_r) begin
          diag_nxt = a_rd; pend_nxt = 1'b0; a_ra = {i_r, j_r};
        end else begin
          div_num = side_r ? 33'(signed'(b_rd)) : -33'(signed'(a_rd));
          if (!side_r && j_r == i_r) begin
            alf_we = 1'b1; alf_wd = '0;
            if (last_j) begin
              side_nxt = 1'b1; b_ra = i_r; pend_nxt = 1'b0;
            end else j_nxt = j_r + 1'b1;
            a_ra = {i_r, j_nxt};
            if (last_j) st_nxt = S_INIT;
          end else begin
            div_go = 1'b1; st_nxt = S_DWAIT;
          end
        end
      end
      S_INIT: begin
        // bubble state so the rhs read lands
        st_nxt = S_DGO;
      end
      S_DWAIT: begin
        if (div_done) begin
          if (side_r) begin
            bet_we = 1'b1;
            if (last_i) begin
              i_nxt = '0; j_nxt = '0; st_nxt = S_SRD;
            end else begin
              i_nxt = i_r + 1'b1; j_nxt = '0; st_nxt = S_DRD;
            end
          end else begin
            alf_we = 1'b1;
            if (last_j) begin
              side_nxt = 1'b1; b_ra = i_r; st_nxt = S_INIT;
            end else begin
              j_nxt = j_r + 1'b1; a_ra = {i_r, j_nxt}; st_nxt = S_DGO;
            end
          end
        end
      end
      // sweep: issue reads for (i,j), then multiply, then accumulate
      S_SRD: begin
        acc_nxt = '0; st_nxt = S_SMAC; pend_nxt = 1'b0;
      end
      S_SMAC: begin
        st_nxt = S_SACC;
      end
      S_SACC: begin
        acc_nxt = acc_r + prod_sh;
        if (last_j) begin
          j_nxt = '0; st_nxt = S_SEND; pend_nxt = 1'b0;
        end else begin
          // fetch the next coefficient so it lands with the next column
          j_nxt = j_r + 1'b1; alf_ra = {i_r, j_nxt}; st_nxt = S_SMAC;
        end
      end
      S_SEND: begin
        // add bet first, then saturate and take the change of row i
        if (!pend_r) begin
          acc_nxt = sum; pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (i_r == '0 || dabs > maxc_r) maxc_nxt = dabs;
          if (last_i) begin
            i_nxt = '0;
            sw_nxt = sw_r + 1'b1;
            // copy the row buffer into the iterate registers on the way out
            st_nxt = S_ORD;
          end else begin
            i_nxt = i_r + 1'b1; st_nxt = S_SRD;
          end
        end
      end
      S_ORD: begin
        if (maxc_r <= {1'b0, tol_r} || sw_r >= limu_r) begin
          stat_nxt = (maxc_r <= {1'b0, tol_r}) ? STAT_CONV : STAT_LIMIT;
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_SRD;
        end
        i_nxt = '0; j_nxt = '0;
      end
      S_OUT: begin
        if (last_i) st_nxt = S_IDLE;
        else i_nxt = i_r + 1'b1;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // New iterates are staged in a row buffer and copied into the iterate
  // registers at the end of the sweep, so every row reads only the previous
  // sweep's values.
  logic signed [31:0] xn_r [MAX_N];
  logic copy;
  assign copy = (st_r == S_ORD);

  always_ff @(posedge clk) begin
    if (st_r == S_SEND && pend_r) xn_r[i_r] <= s_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; j_r <= '0; n_r <= NW'(2); sw_r <= '0;
      limu_r <= 16'd1; maxc_r <= '0; stat_r <= STAT_CONV; zd_r <= 1'b0;
      side_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; n_r <= n_nxt; sw_r <= sw_nxt;
      limu_r <= limu_nxt; maxc_r <= maxc_nxt; stat_r <= stat_nxt; zd_r <= zd_nxt;
      side_r <= side_nxt; pend_r <= pend_nxt;
    end
    acc_r <= acc_nxt; diag_r <= diag_nxt;
    prod_r <= 64'(signed'(alf_rd)) * 64'(signed'(xo_r[j_r]));
  end

  // Cleared on a solve word, loaded with bet during setup and from the row buffer after a sweep.
  always_ff @(posedge clk) begin
    if (st_r == S_DWAIT && div_done && side_r) xo_r[i_r] <= div_q;
    if (copy) begin
      for (int k = 0; k < MAX_N; k++) xo_r[k] <= xn_r[k];
    end
    if (st_r == S_IDLE && in_ok && in_word.kind == KIND_SOLVE) begin
      for (int k = 0; k < MAX_N; k++) xo_r[k] <= '0;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  always_comb begin
    out_word.index = 4'(i_r);
    out_word.solution_value = (stat_r == STAT_ZDIAG) ? 32'sd0 : xo_r[i_r];
    out_word.last = last_i;
    out_word.sweeps = (stat_r == STAT_ZDIAG) ? 16'd0 : sw_r;
    out_word.status = stat_r;
  end
endmodule

FILE: verif/testbench.sv
// Testbench for jacobi_linear_solver_core: loads random and directed systems,
// predicts every solution word in a Jacobi solver model of its own and checks
// each strobed result. Depends on jls_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
  import jls_pkg::*;

  localparam int MaxN          = 16;
  localparam int Frac          = 16;
  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles  = 64;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_word_t        in_word = '0;
  logic            out_valid;
  out_word_t       out_word;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = REG_SIZE;
  logic [CfgW-1:0] cfg_data = '0;

  jacobi_linear_solver_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic signed [31:0] coef_model[MaxN*MaxN];
  logic signed [31:0] rhs_model[MaxN];
  logic [4:0]         size_model = 5'd16;
  logic [30:0]        tol_model = 31'd1;
  logic [15:0]        limit_model = 16'd1000;

  // Stimulus-side view of what has been loaded
  logic signed [31:0] coef_loaded[MaxN*MaxN];
  bit                 coef_written[MaxN*MaxN];
  bit                 rhs_written[MaxN];

  in_word_t  pending_words[$];
  out_word_t expected_solution[$];
  int        idle_pct = 0;
  int        error_count = 0;
  int        quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fix_div(longint num, logic signed [31:0] den);
    longint q;
    q = (num * 64'sd65536) / longint'(den);
    return clamp32(q);
  endfunction

  function automatic void predict_solution();
    int                 n;
    int                 lim;
    int                 sweeps;
    bit                 zero_diag;
    logic signed [31:0] alf[MaxN*MaxN];
    logic signed [31:0] bet[MaxN];
    logic signed [31:0] xp[MaxN];
    logic signed [31:0] xc[MaxN];
    longint             acc;
    longint             dv;
    logic [31:0]        diff;
    logic [31:0]        max_chg;
    logic [1:0]         stat;
    out_word_t          w;
    n = int'(size_model);
    if (n < 2) n = 2;
    if (n > MaxN) n = MaxN;
    lim = (limit_model == 0) ? 1 : int'(limit_model);
    zero_diag = 0;
    sweeps = 0;
    max_chg = 0;
    for (int i = 0; i < n; i++)
      if (coef_model[i*MaxN+i] == 0) zero_diag = 1;
    if (zero_diag) begin
      for (int i = 0; i < n; i++) xc[i] = 0;
      stat = STAT_ZDIAG;
    end else begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++)
          alf[i*MaxN+j] = (i == j) ? 32'sd0 :
              fix_div(-longint'(coef_model[i*MaxN+j]), coef_model[i*MaxN+i]);
        bet[i] = fix_div(longint'(rhs_model[i]), coef_model[i*MaxN+i]);
        xc[i] = bet[i];
      end
      do begin
        for (int i = 0; i < n; i++) xp[i] = xc[i];
        max_chg = 0;
        for (int i = 0; i < n; i++) begin
          acc = longint'(bet[i]);
          // products round toward minus infinity
          for (int j = 0; j < n; j++)
            acc += (longint'(alf[i*MaxN+j]) * longint'(xp[j])) >>> Frac;
          xc[i] = clamp32(acc);
          dv = longint'(xp[i]) - longint'(xc[i]);
          if (dv < 0) dv = -dv;
          diff = dv[31:0];
          if (i == 0 || diff > max_chg) max_chg = diff;
        end
        sweeps++;
      end while (!(max_chg <= {1'b0, tol_model} || sweeps >= lim));
      stat = (max_chg <= {1'b0, tol_model}) ? STAT_CONV : STAT_LIMIT;
    end
    for (int i = 0; i < n; i++) begin
      w.index = i[3:0];
      w.solution_value = xc[i];
      w.last = (i == n - 1);
      w.sweeps = sweeps[15:0];
      w.status = stat;
      expected_solution.push_back(w);
    end
  endfunction

  function automatic void apply_word(in_word_t w);
    case (w.kind)
      KIND_MATRIX: coef_model[w.row*MaxN + w.col] = w.value;
      KIND_RHS:    rhs_model[w.row] = w.value;
      KIND_SOLVE:  predict_solution();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Driver: hold a word while busy, otherwise advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_word(in_word);
      if (!(start && busy)) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_solution.size() == 0) begin
          $display("unexpected result word at %0t, index %0d", $realtime, out_word.index);
          error_count++;
        end else begin
          want = expected_solution.pop_front();
          if (out_word.index !== want.index)
            report_mismatch("index", out_word.index, want.index);
          if (out_word.solution_value !== want.solution_value)
            report_mismatch("solution_value", out_word.solution_value, want.solution_value);
          if (out_word.last !== want.last)
            report_mismatch("last", out_word.last, want.last);
          if (out_word.sweeps !== want.sweeps)
            report_mismatch("sweeps", out_word.sweeps, want.sweeps);
          if (out_word.status !== want.status)
            report_mismatch("status", out_word.status, want.status);
        end
      end
      if (out_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog expired at %0t", $realtime);
        $display("** jacobi_linear_solver_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_word(logic [1:0] kind, int r, int c, logic signed [31:0] v);
    in_word_t w;
    w.kind = kind;
    w.row = r[3:0];
    w.col = c[3:0];
    w.value = v;
    if (kind == KIND_MATRIX) begin
      coef_written[r*MaxN+c] = 1;
      coef_loaded[r*MaxN+c] = v;
    end
    if (kind == KIND_RHS) rhs_written[r] = 1;
    pending_words.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() > 0 || start || expected_solution.size() > 0);
    repeat (SettleCycles) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SIZE:  size_model = data[4:0];
      REG_TOL:   tol_model = data[30:0];
      REG_LIMIT: limit_model = data[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int sz, logic [30:0] tol, int lim);
    wait_idle();
    write_reg(REG_SIZE, CfgW'(sz));
    write_reg(REG_TOL, tol);
    write_reg(REG_LIMIT, CfgW'(lim));
  endtask

  function automatic logic signed [31:0] pick_coef(bit diag);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return $urandom;
    if (diag) begin
      r = $urandom_range(2 << 16, 16 << 16);
      return $urandom_range(0, 1) ? r : -r;
    end
    return $urandom_range(0, 1 << 16) - (1 << 15);
  endfunction

  // One system: entries in use loaded, a diagonal maybe zeroed, then a solve
  task automatic queue_system(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        k = i*MaxN + j;
        if (!coef_written[k] || (i == j && coef_loaded[k] == 0) ||
            $urandom_range(0, 3) == 0)
          push_word(KIND_MATRIX, i, j, pick_coef(i == j));
        if ($urandom_range(0, 15) == 0) push_word(2'd3, $urandom, $urandom, $urandom);
      end
      if (!rhs_written[i] || $urandom_range(0, 1) == 0)
        push_word(KIND_RHS, i, 0, ($urandom_range(0, 7) == 0) ? $urandom :
                  $urandom_range(0, 1 << 22) - (1 << 21));
    end
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, n - 1);
      push_word(KIND_MATRIX, k, k, 0);
    end
    push_word(KIND_SOLVE, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sz;
    logic [30:0] tol;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero diagonal, ignored kind, size clamping
    set_regs(2, 31'd0, 1);
    push_word(KIND_MATRIX, 0, 0, 32'sh00010000);
    push_word(KIND_MATRIX, 0, 1, 32'sh7fffffff);
    push_word(KIND_MATRIX, 1, 0, 32'sh80000000);
    push_word(KIND_MATRIX, 1, 1, 32'sh00020000);
    push_word(KIND_RHS, 0, 0, 32'sh7fffffff);
    push_word(KIND_RHS, 1, 15, 32'sh80000000);
    push_word(KIND_SOLVE, 0, 0, 0);
    push_word(KIND_MATRIX, 1, 1, 0);
    push_word(KIND_SOLVE, 15, 15, -1);
    push_word(2'd3, 15, 15, 32'sh7fffffff);
    push_word(KIND_MATRIX, 1, 1, -1);
    push_word(KIND_MATRIX, 0, 1, 32'sh00004000);
    push_word(KIND_MATRIX, 1, 0, -32'sh00004000);
    push_word(KIND_SOLVE, 0, 0, 0);
    set_regs(0, 31'h7fffffff, 0);
    push_word(KIND_MATRIX, 1, 1, 32'sh00030000);
    push_word(KIND_SOLVE, 0, 0, 0);
    set_regs(1, 31'd1, 50);
    push_word(KIND_SOLVE, 0, 0, 0);
    // Wider system, held to one sweep by the tolerance
    set_regs(8, 31'h7fffffff, 65535);
    queue_system(8);

    // Random phases with rotating sender idling
    for (int p = 0; p < 8; p++) begin
      sz = $urandom_range(2, 5);
      case ($urandom_range(0, 2))
        0: tol = 31'd0;
        1: tol = 31'd1;
        default: tol = 31'($urandom_range(0, 1 << 12));
      endcase
      set_regs(sz, tol, $urandom_range(1, 30));
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 24;
      endcase
      queue_system(sz);
    end

    wait_idle();
    if (error_count == 0) begin
      $display("** jacobi_linear_solver_core: PASSED **");
    end else begin
      $display("** jacobi_linear_solver_core: FAILED **");
    end
    $finish;
  end

endmodule
